>>> src/lrua_pkg.sv
// Shared types, constants and fixed-point helpers for the lens undistortion remap unit.
package lrua_pkg;

  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 1024;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TANG_P1 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TANG_P2 = 4'd7;

  localparam logic [19:0] FOCAL_X_RST  = 20'd117415;
  localparam logic [19:0] FOCAL_Y_RST  = 20'd117068;
  localparam logic [19:0] CENTER_X_RST = 20'd94007;
  localparam logic [19:0] CENTER_Y_RST = 20'd63584;
  localparam logic signed [31:0] K1_RST = -32'sd76076786;
  localparam logic signed [31:0] K2_RST = 32'sd19853237;
  localparam logic signed [31:0] P1_RST = 32'sd51966;
  localparam logic signed [31:0] P2_RST = 32'sd4730;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [39:0] Q_ONE   = 40'sd268435456;

  localparam int DIV_STAGES = 8;
  localparam int DIV_BITS   = 4;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int DIST_LAT   = 9;
  localparam int MAP_LAT    = 2;

  typedef logic signed [31:0] q28_t;
  typedef logic signed [63:0] prod_t;

  function automatic q28_t sat32(input logic signed [39:0] v);
    q28_t r;
    if (v > 40'(S32_MAX)) r = S32_MAX;
    else if (v < 40'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic q28_t qfin(input prod_t p);
    logic signed [35:0] s;
    s = p[63:28];
    return sat32(40'(s));
  endfunction

endpackage

>>> src/lrua_norm_div.sv
// Pipelined restoring divider that normalizes one pixel coordinate to signed Q4.28.
module lrua_norm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [9:0]         pix,
  input  logic [19:0]        center,
  input  logic [19:0]        focal,
  output logic               out_vld,
  output lrua_pkg::q28_t     q_out
);

  localparam int STAGES = lrua_pkg::DIV_STAGES;
  localparam int BITS   = lrua_pkg::DIV_BITS;

  logic              vld_r [0:STAGES];
  logic [19:0]       rem_r [0:STAGES];
  logic [31:0]       num_r [0:STAGES];
  logic [31:0]       quo_r [0:STAGES];
  logic              neg_r [0:STAGES];
  logic              ovf_r [0:STAGES];
  logic [19:0]       rem_nxt [1:STAGES];
  logic [31:0]       num_nxt [1:STAGES];
  logic [31:0]       quo_nxt [1:STAGES];

  logic signed [21:0] d;
  logic [20:0]        mag;
  logic               out_vld_r;
  lrua_pkg::q28_t     q_r, q_nxt;

  always_comb begin
    d   = $signed({4'b0000, pix, 8'b0}) - $signed({2'b00, center});
    mag = d[21] ? 21'(-d) : d[20:0];
  end

  always_comb begin
    logic [19:0] r;
    logic [31:0] n;
    logic [31:0] q;
    logic [20:0] t;
    for (int s = 0; s < STAGES; s++) begin
      r = rem_r[s];
      n = num_r[s];
      q = quo_r[s];
      for (int b = 0; b < BITS; b++) begin
        t = {r, n[31]};
        n = {n[30:0], 1'b0};
        if (t >= {1'b0, focal}) begin
          r = 20'(t - {1'b0, focal});
          q = {q[30:0], 1'b1};
        end else begin
          r = t[19:0];
          q = {q[30:0], 1'b0};
        end
      end
      rem_nxt[s+1] = r;
      num_nxt[s+1] = n;
      quo_nxt[s+1] = q;
    end
  end

  always_comb begin
    logic [31:0] q;
    q = quo_r[STAGES];
    if (ovf_r[STAGES]) q_nxt = neg_r[STAGES] ? lrua_pkg::S32_MIN : lrua_pkg::S32_MAX;
    else if (neg_r[STAGES]) q_nxt = (q > 32'h80000000) ? lrua_pkg::S32_MIN : $signed(-q);
    else q_nxt = (q > 32'h7FFFFFFF) ? lrua_pkg::S32_MAX : $signed(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= STAGES; s++) vld_r[s] <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int s = 1; s <= STAGES; s++) vld_r[s] <= vld_r[s-1];
      out_vld_r <= vld_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= {4'b0, mag[19:4]};
    num_r[0] <= {mag[3:0], 28'b0};
    quo_r[0] <= 32'b0;
    neg_r[0] <= d[21];
    ovf_r[0] <= {3'b0, mag} >= {focal, 4'b0};
    for (int s = 1; s <= STAGES; s++) begin
      rem_r[s] <= rem_nxt[s];
      num_r[s] <= num_nxt[s];
      quo_r[s] <= quo_nxt[s];
      neg_r[s] <= neg_r[s-1];
      ovf_r[s] <= ovf_r[s-1];
    end
    q_r <= q_nxt;
  end

  assign out_vld = out_vld_r;
  assign q_out   = q_r;

endmodule

>>> src/lrua_distort.sv
// Pipelined radial and tangential distortion of a normalized Q4.28 coordinate.
module lrua_distort (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  lrua_pkg::q28_t x,
  input  lrua_pkg::q28_t y,
  input  lrua_pkg::q28_t k1,
  input  lrua_pkg::q28_t k2,
  input  lrua_pkg::q28_t p1,
  input  lrua_pkg::q28_t p2,
  output logic           out_vld,
  output lrua_pkg::q28_t xd,
  output lrua_pkg::q28_t yd
);

  localparam int LAT = lrua_pkg::DIST_LAT;

  logic [LAT-1:0] vld_r;

  lrua_pkg::prod_t pxx_a_r, pyy_a_r, pxy_a_r;
  lrua_pkg::q28_t  x_a_r, y_a_r;
  lrua_pkg::q28_t  xx_b_r, yy_b_r, xy_b_r, x_b_r, y_b_r;
  lrua_pkg::q28_t  r2_c_r, xx_c_r, yy_c_r, xy_c_r, x_c_r, y_c_r;
  lrua_pkg::prod_t prr_d_r, pk1_d_r, pp1_d_r, pp2_d_r;
  lrua_pkg::q28_t  tx_d_r, ty_d_r, x_d_r, y_d_r;
  lrua_pkg::q28_t  r4_e_r, k1r2_e_r, p1xy_e_r, p2xy_e_r, x_e_r, y_e_r;
  lrua_pkg::prod_t ptx_e_r, pty_e_r;
  lrua_pkg::prod_t pk2_f_r;
  lrua_pkg::q28_t  p2tx_f_r, p1ty_f_r, k1r2_f_r, p1xy_f_r, p2xy_f_r, x_f_r, y_f_r;
  lrua_pkg::q28_t  rad_g_r, p2tx_g_r, p1ty_g_r, p1xy_g_r, p2xy_g_r, x_g_r, y_g_r;
  lrua_pkg::prod_t pxr_h_r, pyr_h_r;
  lrua_pkg::q28_t  p2tx_h_r, p1ty_h_r, p1xy_h_r, p2xy_h_r;
  lrua_pkg::q28_t  xd_i_r, yd_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    pxx_a_r <= x * x;
    pyy_a_r <= y * y;
    pxy_a_r <= x * y;
    x_a_r   <= x;
    y_a_r   <= y;

    xx_b_r <= lrua_pkg::qfin(pxx_a_r);
    yy_b_r <= lrua_pkg::qfin(pyy_a_r);
    xy_b_r <= lrua_pkg::qfin(pxy_a_r);
    x_b_r  <= x_a_r;
    y_b_r  <= y_a_r;

    r2_c_r <= lrua_pkg::sat32(40'(xx_b_r) + 40'(yy_b_r));
    xx_c_r <= xx_b_r;
    yy_c_r <= yy_b_r;
    xy_c_r <= xy_b_r;
    x_c_r  <= x_b_r;
    y_c_r  <= y_b_r;

    prr_d_r <= r2_c_r * r2_c_r;
    pk1_d_r <= k1 * r2_c_r;
    pp1_d_r <= p1 * xy_c_r;
    pp2_d_r <= p2 * xy_c_r;
    tx_d_r  <= lrua_pkg::sat32(40'(r2_c_r) + 40'(xx_c_r) + 40'(xx_c_r));
    ty_d_r  <= lrua_pkg::sat32(40'(r2_c_r) + 40'(yy_c_r) + 40'(yy_c_r));
    x_d_r   <= x_c_r;
    y_d_r   <= y_c_r;

    r4_e_r   <= lrua_pkg::qfin(prr_d_r);
    k1r2_e_r <= lrua_pkg::qfin(pk1_d_r);
    p1xy_e_r <= lrua_pkg::qfin(pp1_d_r);
    p2xy_e_r <= lrua_pkg::qfin(pp2_d_r);
    ptx_e_r  <= p2 * tx_d_r;
    pty_e_r  <= p1 * ty_d_r;
    x_e_r    <= x_d_r;
    y_e_r    <= y_d_r;

    pk2_f_r  <= k2 * r4_e_r;
    p2tx_f_r <= lrua_pkg::qfin(ptx_e_r);
    p1ty_f_r <= lrua_pkg::qfin(pty_e_r);
    k1r2_f_r <= k1r2_e_r;
    p1xy_f_r <= p1xy_e_r;
    p2xy_f_r <= p2xy_e_r;
    x_f_r    <= x_e_r;
    y_f_r    <= y_e_r;

    rad_g_r  <= lrua_pkg::sat32(lrua_pkg::Q_ONE + 40'(k1r2_f_r)
                                + 40'(lrua_pkg::qfin(pk2_f_r)));
    p2tx_g_r <= p2tx_f_r;
    p1ty_g_r <= p1ty_f_r;
    p1xy_g_r <= p1xy_f_r;
    p2xy_g_r <= p2xy_f_r;
    x_g_r    <= x_f_r;
    y_g_r    <= y_f_r;

    pxr_h_r  <= x_g_r * rad_g_r;
    pyr_h_r  <= y_g_r * rad_g_r;
    p2tx_h_r <= p2tx_g_r;
    p1ty_h_r <= p1ty_g_r;
    p1xy_h_r <= p1xy_g_r;
    p2xy_h_r <= p2xy_g_r;

    xd_i_r <= lrua_pkg::sat32(40'(lrua_pkg::qfin(pxr_h_r)) + 40'(p1xy_h_r) + 40'(p1xy_h_r)
                              + 40'(p2tx_h_r));
    yd_i_r <= lrua_pkg::sat32(40'(lrua_pkg::qfin(pyr_h_r)) + 40'(p1ty_h_r) + 40'(p2xy_h_r)
                              + 40'(p2xy_h_r));
  end

  assign out_vld = vld_r[LAT-1];
  assign xd      = xd_i_r;
  assign yd      = yd_i_r;

endmodule

>>> src/lens_undistort_remap_address_unit.sv
// Top level of the lens undistortion remap address unit: registers, pipeline and back-mapping.
//
// Usage:
//   Input channel: drive in_out_col / in_out_row with start high; the item
//   transfers at any rising edge with start high, since busy stays low.
//   A new coordinate may enter on every clock: throughput is one item per cycle.
//   Result channel: out_strobe is high for one cycle with out_src_col,
//   out_src_row and out_inside_res; the receiver cannot stall the result.
//   From transfer to strobe an item passes the normalizing divider (eight
//   stages of four quotient bits each), the distortion multiplier pipeline
//   and the back-mapping and inside-test registers.
//   When out_inside_res is low all result fields are zero; fields are also
//   zero in cycles without a strobe.
//   Configuration: cfg_we with cfg_index and cfg_data writes one register at
//   the clock edge; write only while no item is in flight. Indexes beyond
//   the register list are ignored.
//   Reset (rst_n low, synchronous) restores the default intrinsics and
//   coefficients and empties the pipeline; items in flight are dropped.
module lens_undistort_remap_address_unit #(
  parameter int IMAGE_WIDTH  = lrua_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = lrua_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [9:0]                      in_out_col,
  input  logic [9:0]                      in_out_row,
  output logic                            out_strobe,
  output logic [9:0]                      out_src_col,
  output logic [9:0]                      out_src_row,
  output logic                            out_inside_res,
  input  logic                            cfg_we,
  input  logic [lrua_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrua_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [26:0] U_LIMIT = 27'(IMAGE_WIDTH * 256);
  localparam logic signed [26:0] V_LIMIT = 27'(IMAGE_HEIGHT * 256);

  logic [19:0]    focal_x_r, focal_y_r, center_x_r, center_y_r;
  lrua_pkg::q28_t k1_r, k2_r, p1_r, p2_r;

  logic           accept;
  logic           xv, yv, dv;
  lrua_pkg::q28_t xn, yn, xd, yd;

  logic              map_vld_r;
  logic signed [52:0] pu_r, pv_r;
  logic signed [26:0] uq, vq;
  logic              in_image;

  logic       strobe_r, inside_r;
  logic [9:0] col_r, row_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= lrua_pkg::FOCAL_X_RST;
      focal_y_r  <= lrua_pkg::FOCAL_Y_RST;
      center_x_r <= lrua_pkg::CENTER_X_RST;
      center_y_r <= lrua_pkg::CENTER_Y_RST;
      k1_r       <= lrua_pkg::K1_RST;
      k2_r       <= lrua_pkg::K2_RST;
      p1_r       <= lrua_pkg::P1_RST;
      p2_r       <= lrua_pkg::P2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrua_pkg::REG_FOCAL_X:   focal_x_r  <= cfg_data[19:0];
        lrua_pkg::REG_FOCAL_Y:   focal_y_r  <= cfg_data[19:0];
        lrua_pkg::REG_CENTER_X:  center_x_r <= cfg_data[19:0];
        lrua_pkg::REG_CENTER_Y:  center_y_r <= cfg_data[19:0];
        lrua_pkg::REG_RADIAL_K1: k1_r       <= $signed(cfg_data);
        lrua_pkg::REG_RADIAL_K2: k2_r       <= $signed(cfg_data);
        lrua_pkg::REG_TANG_P1:   p1_r       <= $signed(cfg_data);
        lrua_pkg::REG_TANG_P2:   p2_r       <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  lrua_norm_div u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (accept),
    .pix    (in_out_col),
    .center (center_x_r),
    .focal  (focal_x_r),
    .out_vld(xv),
    .q_out  (xn)
  );

  lrua_norm_div u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (accept),
    .pix    (in_out_row),
    .center (center_y_r),
    .focal  (focal_y_r),
    .out_vld(yv),
    .q_out  (yn)
  );

  lrua_distort u_distort (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (xv & yv),
    .x      (xn),
    .y      (yn),
    .k1     (k1_r),
    .k2     (k2_r),
    .p1     (p1_r),
    .p2     (p2_r),
    .out_vld(dv),
    .xd     (xd),
    .yd     (yd)
  );

  always_ff @(posedge clk) begin
    pu_r <= $signed({1'b0, focal_x_r}) * xd;
    pv_r <= $signed({1'b0, focal_y_r}) * yd;
  end

  always_comb begin
    uq = 27'(pu_r >>> 28) + $signed({7'b0, center_x_r});
    vq = 27'(pv_r >>> 28) + $signed({7'b0, center_y_r});
    in_image = (uq >= 0) && (vq >= 0) && (uq < U_LIMIT) && (vq < V_LIMIT)
               && (focal_x_r != 20'd0) && (focal_y_r != 20'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= 1'b0;
      strobe_r  <= 1'b0;
      inside_r  <= 1'b0;
      col_r     <= 10'd0;
      row_r     <= 10'd0;
    end else begin
      map_vld_r <= dv;
      strobe_r  <= map_vld_r;
      inside_r  <= map_vld_r & in_image;
      col_r     <= (map_vld_r & in_image) ? uq[17:8] : 10'd0;
      row_r     <= (map_vld_r & in_image) ? vq[17:8] : 10'd0;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_inside_res = inside_r;
  assign out_src_col    = col_r;
  assign out_src_row    = row_r;

`ifndef SYNTHESIS
  a_inside_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_inside_res |-> out_strobe)
    else $error("inside flag without result strobe");

  a_zero_focal_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (focal_x_r == 20'd0 || focal_y_r == 20'd0)) |-> !out_inside_res)
    else $error("inside result with zero focal length");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_inside_res |-> (out_src_col == 10'd0 && out_src_row == 10'd0))
    else $error("nonzero source address on outside result");

  a_strobe_follows_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(xv) |-> (xv == yv))
    else $error("divider lanes out of step");
`endif

endmodule
